// ===== rtl/core/kla_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad lock and alarm controller package
// Shared types, key and action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package kla_pkg;

    localparam int CODE_LEN_DEF = 4;
    localparam int OUT_SLOTS    = 4;

    localparam logic [4:0] SLOT_EMPTY = 5'd16;

    // decoded key codes
    localparam logic [3:0] KEY_HASH = 4'd14;
    localparam logic [3:0] KEY_STAR = 4'd15;

    // event codes
    localparam logic [1:0] ACT_KEY    = 2'd0;
    localparam logic [1:0] ACT_MOTION = 2'd1;
    localparam logic [1:0] ACT_DOOR   = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_FAIL_THR = 2'd0;
    localparam logic [1:0] CFG_UNLOCK   = 2'd1;
    localparam logic [1:0] CFG_LOCK     = 2'd2;

    localparam logic [3:0]  FAIL_THR_RST = 4'd3;
    localparam logic [14:0] UNLOCK_RST   = 15'd2300;
    localparam logic [14:0] LOCK_RST     = 15'd700;
    localparam logic [3:0]  FAIL_MAX     = 4'd15;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_SET      = 2'd2
    } t_mode;

    typedef struct packed {
        logic [3:0]  fail_thr;
        logic [14:0] unlock_pulse;
        logic [14:0] lock_pulse;
    } t_cfg;

    typedef struct packed {
        t_mode                       mode;
        logic [14:0]                 servo_pulse;
        logic                        motion_alarm;
        logic                        door_alarm;
        logic                        fail_alarm;
        logic [3:0]                  fail_count;
        logic [OUT_SLOTS-1:0][4:0]   entry;
    } t_result;

endpackage

// ===== rtl/core/keypad_lock_alarm_controller.sv =====
// ----------------------------------------------------------------------------
// Keypad lock and alarm controller
// Channel   Direction  Handshake          Word
// events    in         i_valid / o_stall  action, key code, sensor level
// results   out        o_valid / i_stall  mode, servo, alarms, count, entries
// config    in         i_cfg_wr_en        index, data (no read-back)
//
// One event a cycle while results are taken; an event passes through the input
// register, then through the event logic into the result register.
// Synchronous active-low reset; no clearing pass, ready straight after reset.
// A stalled result holds its register; the input register keeps taking
// events while the result register has room or is being emptied.
// ----------------------------------------------------------------------------
module keypad_lock_alarm_controller #(
    parameter int CODE_LEN = kla_pkg::CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_key_code,
    input  logic        i_sensor_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_mode,
    output logic [14:0] o_servo_pulse,
    output logic        o_motion_alarm,
    output logic        o_door_alarm,
    output logic        o_fail_alarm,
    output logic [3:0]  o_fail_count,
    output logic [4:0]  o_entry_0,
    output logic [4:0]  o_entry_1,
    output logic [4:0]  o_entry_2,
    output logic [4:0]  o_entry_3,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_wdata
);
    import kla_pkg::*;

    logic       r_in_vld;
    logic [1:0] r_in_action;
    logic [3:0] r_in_key;
    logic       r_in_level;

    logic    out_room, step, accept;
    t_cfg    cfg;
    t_result core_res, out_res;

    assign out_room = !o_valid || !i_stall;
    assign step     = r_in_vld && out_room;
    assign o_stall  = r_in_vld && !out_room;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_vld <= 1'b0;
        else if (accept)
            r_in_vld <= 1'b1;
        else if (step)
            r_in_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_action <= i_action;
            r_in_key    <= i_key_code;
            r_in_level  <= i_sensor_level;
        end
    end

    kla_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    kla_core #(
        .CODE_LEN (CODE_LEN)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_action       (r_in_action),
        .i_key_code     (r_in_key),
        .i_sensor_level (r_in_level),
        .i_cfg          (cfg),
        .o_res          (core_res)
    );

    kla_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_take  (!i_stall),
        .i_res   (core_res),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_mode         = out_res.mode;
    assign o_servo_pulse  = out_res.servo_pulse;
    assign o_motion_alarm = out_res.motion_alarm;
    assign o_door_alarm   = out_res.door_alarm;
    assign o_fail_alarm   = out_res.fail_alarm;
    assign o_fail_count   = out_res.fail_count;
    assign o_entry_0      = out_res.entry[0];
    assign o_entry_1      = out_res.entry[1];
    assign o_entry_2      = out_res.entry[2];
    assign o_entry_3      = out_res.entry[3];

endmodule

// ===== rtl/core/kla_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Fail threshold and the two servo pulse widths, plain write port.
// ----------------------------------------------------------------------------
module kla_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [1:0]     i_idx,
    input  logic [14:0]    i_wdata,
    output kla_pkg::t_cfg  o_cfg
);
    import kla_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_thr     <= FAIL_THR_RST;
            r_cfg.unlock_pulse <= UNLOCK_RST;
            r_cfg.lock_pulse   <= LOCK_RST;
        end else if (i_wr_en) begin
            unique case (i_idx)
                CFG_FAIL_THR: r_cfg.fail_thr     <= i_wdata[3:0];
                CFG_UNLOCK:   r_cfg.unlock_pulse <= i_wdata;
                CFG_LOCK:     r_cfg.lock_pulse   <= i_wdata;
                default:      ;  // no register there
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/kla_core.sv =====
// ----------------------------------------------------------------------------
// Lock state and event logic
// Holds mode, entry and code rings, fail count, lamps and servo; computes
// the state after one event and the result word that shows it.
// ----------------------------------------------------------------------------
module kla_core #(
    parameter int CODE_LEN = kla_pkg::CODE_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [1:0]        i_action,
    input  logic [3:0]        i_key_code,
    input  logic              i_sensor_level,
    input  kla_pkg::t_cfg     i_cfg,
    output kla_pkg::t_result  o_res
);
    import kla_pkg::*;

    localparam int PTR_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CODE_LEN - 1);

    t_mode                     r_mode,  n_mode;
    logic [CODE_LEN-1:0][4:0]  r_entry, n_entry;
    logic [CODE_LEN-1:0][4:0]  r_code,  n_code;
    logic [PTR_W-1:0]          r_eptr,  n_eptr;
    logic [PTR_W-1:0]          r_cptr,  n_cptr;
    logic [3:0]                r_fail,  n_fail;
    logic                      r_door_open, n_door_open;
    logic                      r_motion, n_motion;
    logic                      r_door_lamp, n_door_lamp;
    logic [14:0]               r_servo, n_servo;

    logic is_key, is_digit, is_hash, is_star, match;
    logic [OUT_SLOTS-1:0][4:0] slot_show;

    assign is_key   = i_step && (i_action == ACT_KEY);
    assign is_digit = i_key_code < KEY_HASH;
    assign is_hash  = i_key_code == KEY_HASH;
    assign is_star  = i_key_code == KEY_STAR;

    // empty slot matches only an empty slot
    always_comb begin
        match = 1'b1;
        for (int k = 0; k < CODE_LEN; k++) begin
            if (r_entry[k] != r_code[k])
                match = 1'b0;
        end
    end

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (is_key && !is_digit) begin
            unique case (r_mode)
                MODE_DISARMED: begin
                    if (is_hash && !r_door_open)
                        n_mode = MODE_ARMED;
                    else if (is_star)
                        n_mode = MODE_SET;
                end
                MODE_SET: begin
                    if (is_star)
                        n_mode = MODE_DISARMED;
                end
                MODE_ARMED: begin
                    if (is_star && match)
                        n_mode = MODE_DISARMED;
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // rings, counter, lamps, servo
    always_comb begin
        n_entry     = r_entry;
        n_code      = r_code;
        n_eptr      = r_eptr;
        n_cptr      = r_cptr;
        n_fail      = r_fail;
        n_door_open = r_door_open;
        n_motion    = r_motion;
        n_door_lamp = r_door_lamp;
        n_servo     = r_servo;
        if (i_step) begin
            case (i_action)
                ACT_KEY: begin
                    if (is_digit) begin
                        for (int k = 0; k < CODE_LEN; k++) begin
                            if (r_eptr == PTR_W'(k))
                                n_entry[k] = {1'b0, i_key_code};
                        end
                        n_eptr = (r_eptr == PTR_LAST) ? '0 : r_eptr + 1'b1;
                        if (r_mode == MODE_SET) begin
                            for (int k = 0; k < CODE_LEN; k++) begin
                                if (r_cptr == PTR_W'(k))
                                    n_code[k] = {1'b0, i_key_code};
                            end
                            n_cptr = (r_cptr == PTR_LAST) ? '0 : r_cptr + 1'b1;
                        end
                    end else if (r_mode == MODE_DISARMED) begin
                        if (is_hash) begin
                            if (!r_door_open)
                                n_servo = i_cfg.lock_pulse;
                        end else begin
                            // entries kept, both write pointers rewind and the code ring is cleared
                            for (int k = 0; k < CODE_LEN; k++)
                                n_code[k] = SLOT_EMPTY;
                            n_cptr = '0;
                            n_eptr = '0;
                        end
                    end else if (r_mode == MODE_ARMED && is_star) begin
                        for (int k = 0; k < CODE_LEN; k++)
                            n_entry[k] = SLOT_EMPTY;
                        n_eptr = '0;
                        if (match) begin
                            n_fail  = '0;
                            n_servo = i_cfg.unlock_pulse;
                        end else if (r_fail != FAIL_MAX) begin
                            n_fail = r_fail + 1'b1;
                        end
                    end
                end
                ACT_MOTION: begin
                    if (!i_sensor_level)
                        n_motion = 1'b0;
                    else if (r_mode == MODE_ARMED)
                        n_motion = 1'b1;
                end
                ACT_DOOR: begin
                    n_door_open = i_sensor_level;
                    if (!i_sensor_level)
                        n_door_lamp = 1'b0;
                    else if (r_mode == MODE_ARMED)
                        n_door_lamp = 1'b1;
                end
                default: ;  // unused event code
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISARMED;
            r_eptr      <= '0;
            r_cptr      <= '0;
            r_fail      <= '0;
            r_door_open <= 1'b0;
            r_motion    <= 1'b0;
            r_door_lamp <= 1'b0;
            r_servo     <= '0;
            for (int k = 0; k < CODE_LEN; k++) begin
                r_entry[k] <= SLOT_EMPTY;
                r_code[k]  <= 5'(k + 1);
            end
        end else begin
            r_mode      <= n_mode;
            r_entry     <= n_entry;
            r_code      <= n_code;
            r_eptr      <= n_eptr;
            r_cptr      <= n_cptr;
            r_fail      <= n_fail;
            r_door_open <= n_door_open;
            r_motion    <= n_motion;
            r_door_lamp <= n_door_lamp;
            r_servo     <= n_servo;
        end
    end

    for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_slot
        if (g < CODE_LEN) begin : g_used
            assign slot_show[g] = n_entry[g];
        end else begin : g_unused
            assign slot_show[g] = SLOT_EMPTY;
        end
    end

    // result word shows the state after this event
    always_comb begin
        o_res.mode         = n_mode;
        o_res.servo_pulse  = n_servo;
        o_res.motion_alarm = n_motion;
        o_res.door_alarm   = n_door_lamp;
        o_res.fail_alarm   = (n_mode == MODE_ARMED) && (n_fail >= i_cfg.fail_thr);
        o_res.fail_count   = n_fail;
        o_res.entry        = slot_show;
    end

endmodule

// ===== rtl/core/kla_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module kla_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_take,
    input  kla_pkg::t_result  i_res,
    output logic              o_valid,
    output kla_pkg::t_result  o_res
);
    import kla_pkg::*;

    logic    r_vld;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= 1'b0;
        else if (i_load)
            r_vld <= 1'b1;
        else if (i_take)
            r_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load)
            r_res <= i_res;
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/kla_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports: result hold, alarm and mode consistency, slot range, reset.
// ----------------------------------------------------------------------------
module kla_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_mode,
    input logic [14:0] o_servo_pulse,
    input logic        o_fail_alarm,
    input logic [3:0]  o_fail_count,
    input logic [4:0]  o_entry_0,
    input logic [4:0]  o_entry_1,
    input logic [4:0]  o_entry_2,
    input logic [4:0]  o_entry_3
);
    import kla_pkg::*;

    // a stalled word stays put: mode, servo, fail count and first entry
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mode) && $stable(o_servo_pulse)
            && $stable(o_fail_count) && $stable(o_entry_0))
        else $error("result word changed under stall");

    // fail alarm only ever shows in armed mode
    a_alarm_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fail_alarm |-> o_mode == MODE_ARMED)
        else $error("fail alarm outside armed mode");

    // slots hold a key code or the empty mark
    a_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_0 <= SLOT_EMPTY && o_entry_1 <= SLOT_EMPTY
            && o_entry_2 <= SLOT_EMPTY && o_entry_3 <= SLOT_EMPTY)
        else $error("entry slot out of range");

    // nothing offered in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result offered straight after reset");

endmodule

bind keypad_lock_alarm_controller kla_checker u_kla_checker (.*);

// ===== bench/tb_keypad_lock_alarm_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad lock and alarm controller testbench
// Drives key presses and sensor changes through the valid/stall channel and
// predicts every status word with a cycle-free model of the lock. A second
// copy of that model looks ahead while stimulus is built, so that most random
// sequences are real code entries, arming and unlocking. Both sides of the
// block idle at random, and once the status side holds off long enough for
// the block to stall its input. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_keypad_lock_alarm_controller;
    import kla_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PRINT_MAX   = 100;
    localparam logic [1:0] ACT_NONE    = 2'd3;  // unused action code
    localparam logic [1:0] CFG_NONE    = 2'd3;  // unused register index

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] key;
        logic       level;
    } t_panel_event;

    typedef struct {
        t_mode           mode;
        logic [3:0][4:0] entry;
        logic [1:0]      entry_ptr;
        logic [3:0][4:0] code;
        logic [1:0]      code_ptr;
        logic [3:0]      fails;
        logic            door_open;
        logic            motion_lamp;
        logic            door_lamp;
        logic [14:0]     servo;
    } t_lock_state;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_action       = '0;
    logic [3:0]  i_key_code     = '0;
    logic        i_sensor_level = 1'b0;
    logic        i_stall        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [1:0]  i_cfg_idx      = '0;
    logic [14:0] i_cfg_wdata    = '0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_mode;
    logic [14:0] o_servo_pulse;
    logic        o_motion_alarm;
    logic        o_door_alarm;
    logic        o_fail_alarm;
    logic [3:0]  o_fail_count;
    logic [4:0]  o_entry_0;
    logic [4:0]  o_entry_1;
    logic [4:0]  o_entry_2;
    logic [4:0]  o_entry_3;

    keypad_lock_alarm_controller u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_key_code     (i_key_code),
        .i_sensor_level (i_sensor_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mode         (o_mode),
        .o_servo_pulse  (o_servo_pulse),
        .o_motion_alarm (o_motion_alarm),
        .o_door_alarm   (o_door_alarm),
        .o_fail_alarm   (o_fail_alarm),
        .o_fail_count   (o_fail_count),
        .o_entry_0      (o_entry_0),
        .o_entry_1      (o_entry_1),
        .o_entry_2      (o_entry_2),
        .o_entry_3      (o_entry_3),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    t_panel_event panel_event_q[$];
    t_result      expected_status_q[$];
    t_lock_state  lock_model;   // follows the words the block has taken
    t_lock_state  plan_model;   // runs ahead while stimulus is queued
    t_cfg         lock_cfg;
    int           err_count    = 0;
    int           cycle_count  = 0;
    int           gen_count    = 0;
    int           send_gap_max = 0;
    int           hold_max     = 0;
    int           gap_left     = 0;
    int           stall_left   = 0;
    int           hold_left    = 0;
    bit           word_taken   = 1'b0;
    bit           status_taken = 1'b0;

    function automatic int draw_wait(int max_wait);
        if (max_wait == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    function automatic t_lock_state lock_reset();
        t_lock_state s;
        int          k;
        s.mode      = MODE_DISARMED;
        s.entry     = {4{SLOT_EMPTY}};
        s.entry_ptr = '0;
        for (k = 0; k < 4; k++)
            s.code[k] = 5'(k + 1);
        s.code_ptr    = '0;
        s.fails       = '0;
        s.door_open   = 1'b0;
        s.motion_lamp = 1'b0;
        s.door_lamp   = 1'b0;
        s.servo       = '0;
        return s;
    endfunction

    // next state of the lock for one panel word, and the status it shows
    function automatic t_result lock_step(inout t_lock_state s, input t_cfg c,
                                          input t_panel_event ev);
        t_result r;
        logic    same;
        case (ev.action)
            ACT_KEY: begin
                if (ev.key < KEY_HASH) begin
                    s.entry[s.entry_ptr] = {1'b0, ev.key};
                    s.entry_ptr          = s.entry_ptr + 2'd1;
                    if (s.mode == MODE_SET) begin
                        s.code[s.code_ptr] = {1'b0, ev.key};
                        s.code_ptr         = s.code_ptr + 2'd1;
                    end
                end else if (s.mode == MODE_DISARMED) begin
                    if (ev.key == KEY_HASH) begin
                        if (!s.door_open) begin
                            s.servo = c.lock_pulse;
                            s.mode  = MODE_ARMED;
                        end
                    end else begin
                        s.code      = {4{SLOT_EMPTY}};
                        s.code_ptr  = '0;
                        s.entry_ptr = '0;
                        s.mode      = MODE_SET;
                    end
                end else if (s.mode == MODE_SET) begin
                    if (ev.key == KEY_STAR)
                        s.mode = MODE_DISARMED;
                end else if (ev.key == KEY_STAR) begin
                    // empty slots only match empty slots
                    same        = (s.entry == s.code);
                    s.entry_ptr = '0;
                    s.entry     = {4{SLOT_EMPTY}};
                    if (same) begin
                        s.mode  = MODE_DISARMED;
                        s.fails = '0;
                        s.servo = c.unlock_pulse;
                    end else if (s.fails != FAIL_MAX) begin
                        s.fails = s.fails + 4'd1;
                    end
                end
            end
            ACT_MOTION: begin
                if (!ev.level)
                    s.motion_lamp = 1'b0;
                else if (s.mode == MODE_ARMED)
                    s.motion_lamp = 1'b1;
            end
            ACT_DOOR: begin
                s.door_open = ev.level;
                if (!ev.level)
                    s.door_lamp = 1'b0;
                else if (s.mode == MODE_ARMED)
                    s.door_lamp = 1'b1;
            end
            default: ;
        endcase
        r.mode         = s.mode;
        r.servo_pulse  = s.servo;
        r.motion_alarm = s.motion_lamp;
        r.door_alarm   = s.door_lamp;
        r.fail_alarm   = (s.mode == MODE_ARMED) && (s.fails >= c.fail_thr);
        r.fail_count   = s.fails;
        r.entry        = s.entry;
        return r;
    endfunction

    task automatic check_field(string what, int got, int want);
        if (got != want) begin
            err_count++;
            if (err_count <= PRINT_MAX)
                $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic queue_event(logic [1:0] action, logic [3:0] key, logic level);
        t_panel_event ev;
        ev = '{action, key, level};
        void'(lock_step(plan_model, lock_cfg, ev));
        panel_event_q.push_back(ev);
        gen_count++;
    endtask

    task automatic queue_key(logic [3:0] key);
        queue_event(ACT_KEY, key, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_digits(int n);
        repeat (n) queue_key(4'($urandom_range(0, 13)));
    endtask

    // type in the stored code so that the following star unlocks
    task automatic queue_good_code();
        int k;
        if (plan_model.code[0] != SLOT_EMPTY && plan_model.code[1] != SLOT_EMPTY &&
            plan_model.code[2] != SLOT_EMPTY && plan_model.code[3] != SLOT_EMPTY) begin
            // full code: follow the write pointer round the ring
            repeat (4) queue_key(plan_model.code[plan_model.entry_ptr][3:0]);
        end else begin
            // short code: the unused slots must be empty, so clear the ring first
            if (plan_model.entry != {4{SLOT_EMPTY}} || plan_model.entry_ptr != 0)
                queue_key(KEY_STAR);
            if (plan_model.mode != MODE_ARMED)
                return;
            for (k = 0; k < 4 && plan_model.code[k] != SLOT_EMPTY; k++)
                queue_key(plan_model.code[k][3:0]);
        end
        queue_key(KEY_STAR);
    endtask

    task automatic queue_scenario();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            queue_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
        end else if (pick < 22) begin
            queue_event(2'($urandom_range(1, 2)), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
        end else begin
            case (plan_model.mode)
                MODE_DISARMED: begin
                    if (pick < 50) begin
                        queue_key(KEY_STAR);
                        queue_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4);
                        queue_key(KEY_STAR);
                    end else begin
                        if (plan_model.door_open && $urandom_range(0, 3) != 0)
                            queue_event(ACT_DOOR, 4'($urandom_range(0, 15)), 1'b0);
                        queue_digits($urandom_range(0, 2));
                        queue_key(KEY_HASH);
                    end
                end
                MODE_ARMED: begin
                    if (pick < 58) begin
                        queue_good_code();
                    end else if (pick < 88) begin
                        queue_digits($urandom_range(0, 5));
                        if ($urandom_range(0, 4) == 0)
                            queue_key(KEY_HASH);
                        queue_key(KEY_STAR);
                    end else begin
                        // run the fail count up towards saturation
                        repeat ($urandom_range(12, 18)) queue_key(KEY_STAR);
                    end
                end
                default: begin
                    queue_digits($urandom_range(0, 5));
                    queue_key(KEY_STAR);
                end
            endcase
        end
    endtask

    task automatic wait_idle();
        while (panel_event_q.size() != 0 || expected_status_q.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FAIL_THR: lock_cfg.fail_thr     = data[3:0];
            CFG_UNLOCK:   lock_cfg.unlock_pulse = data;
            CFG_LOCK:     lock_cfg.lock_pulse   = data;
            default: ;
        endcase
    endtask

    task automatic run_random(int n_words, int gap_max, int stall_max, int hold);
        int target;
        send_gap_max = gap_max;
        hold_max     = stall_max;
        if (hold > 0) begin
            @(negedge i_clk);
            hold_left = hold;
        end
        target = gen_count + n_words;
        while (gen_count < target)
            queue_scenario();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // sender: offers queued words on the falling edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        word_taken = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            word_taken = 1'b1;
            expected_status_q.push_back(lock_step(lock_model, lock_cfg,
                                        '{i_action, i_key_code, i_sensor_level}));
        end
    end

    always @(negedge i_clk) begin
        t_panel_event ev;
        if (i_rst_n && (!i_valid || word_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (panel_event_q.size() != 0) begin
                ev = panel_event_q.pop_front();
                i_action       <= ev.action;
                i_key_code     <= ev.key;
                i_sensor_level <= ev.level;
                i_valid        <= 1'b1;
                gap_left = draw_wait(send_gap_max);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall per word, plus a long hold-off when asked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge i_clk) begin
        if (status_taken)
            stall_left = draw_wait(hold_max);
        if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        status_taken = 1'b0;
        if (i_rst_n && o_valid && !i_stall) begin
            status_taken = 1'b1;
            if (expected_status_q.size() == 0) begin
                check_field("unexpected status word", 1, 0);
            end else begin
                want = expected_status_q.pop_front();
                check_field("mode",         o_mode,         want.mode);
                check_field("servo_pulse",  o_servo_pulse,  want.servo_pulse);
                check_field("motion_alarm", o_motion_alarm, want.motion_alarm);
                check_field("door_alarm",   o_door_alarm,   want.door_alarm);
                check_field("fail_alarm",   o_fail_alarm,   want.fail_alarm);
                check_field("fail_count",   o_fail_count,   want.fail_count);
                check_field("entry_0",      o_entry_0,      want.entry[0]);
                check_field("entry_1",      o_entry_1,      want.entry[1]);
                check_field("entry_2",      o_entry_2,      want.entry[2]);
                check_field("entry_3",      o_entry_3,      want.entry[3]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // phases
    // ------------------------------------------------------------------
    initial begin
        lock_model = lock_reset();
        plan_model = lock_reset();
        lock_cfg   = '{FAIL_THR_RST, UNLOCK_RST, LOCK_RST};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the special cases, reset settings
        send_gap_max = 2;
        hold_max     = 2;
        queue_event(ACT_NONE, 4'd15, 1'b1);     // unused action
        queue_key(4'd0);
        queue_key(4'd13);
        queue_event(ACT_DOOR, 4'd7, 1'b1);      // rise while disarmed: level only
        queue_key(KEY_HASH);                    // door open: no arming
        queue_event(ACT_DOOR, 4'd8, 1'b0);
        queue_key(KEY_STAR);                    // set mode, entries kept
        queue_key(KEY_HASH);                    // ignored in set mode
        queue_key(4'd5);
        queue_key(4'd9);
        queue_key(KEY_STAR);
        queue_key(KEY_HASH);                    // arm
        queue_key(KEY_HASH);                    // ignored while armed
        queue_event(ACT_MOTION, 4'd0, 1'b1);
        queue_event(ACT_DOOR, 4'd15, 1'b1);
        queue_key(4'd1);
        queue_key(KEY_STAR);                    // wrong code
        queue_key(KEY_STAR);                    // empty ring against short code
        queue_key(KEY_STAR);                    // reaches the threshold
        queue_event(ACT_MOTION, 4'd3, 1'b0);
        queue_key(4'd5);
        queue_key(4'd9);
        queue_key(KEY_STAR);                    // unlock, door lamp stays lit
        queue_event(ACT_DOOR, 4'd1, 1'b0);
        wait_idle();

        write_reg(CFG_FAIL_THR, 15'd1);
        write_reg(CFG_UNLOCK, 15'd20000);
        write_reg(CFG_LOCK, 15'd0);
        write_reg(CFG_NONE, 15'h7FFF);
        run_random(300, 15, 15, 0);

        // no idling at all
        write_reg(CFG_FAIL_THR, 15'd15);
        write_reg(CFG_UNLOCK, 15'h7FFF);
        write_reg(CFG_LOCK, 15'd20000);
        run_random(300, 0, 0, 0);

        // zero threshold; status side holds off so the block backs up
        write_reg(CFG_FAIL_THR, 15'd0);
        write_reg(CFG_UNLOCK, 15'd0);
        write_reg(CFG_LOCK, 15'h7FFF);
        run_random(300, 3, 3, 200);

        write_reg(CFG_FAIL_THR, {11'($urandom_range(0, 2047)), 4'($urandom_range(1, 15))});
        write_reg(CFG_UNLOCK, 15'($urandom_range(0, 32767)));
        write_reg(CFG_LOCK, 15'($urandom_range(0, 32767)));
        run_random(350, 15, 15, 0);

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
